[sv/trpa_pkg.sv]
// Shared constants and types for the threshold rotating priority arbiter.
package trpa_pkg;

    parameter int NumInputsDef = 8;
    parameter int MaskW        = 8;
    parameter int GrantIdxW    = 3;
    parameter int CountW       = 17;
    parameter int ThreshW      = 16;
    parameter int ApbDataW     = 32;
    parameter int ApbAddrW     = 3;

    // Register index of the threshold register, taken from paddr above the byte offset.
    parameter logic RegThreshold = 1'b0;

    typedef struct packed {
        logic                 grant_valid;
        logic [GrantIdxW-1:0] grant_index;
        logic                 start_moved;
    } t_grant;

endpackage

[sv/trpa_ifs.sv]
// Valid/ready channel interfaces for request masks and grant results.
interface trpa_req_if;
    logic                       valid;
    logic                       ready;
    logic [trpa_pkg::MaskW-1:0] request_mask;

    modport source (output valid, output request_mask, input ready);
    modport sink (input valid, input request_mask, output ready);
endinterface

interface trpa_grant_if;
    logic                           valid;
    logic                           ready;
    logic                           grant_valid;
    logic [trpa_pkg::GrantIdxW-1:0] grant_index;
    logic                           start_moved;

    modport source (output valid, output grant_valid, output grant_index,
                    output start_moved, input ready);
    modport sink (input valid, input grant_valid, input grant_index,
                  input start_moved, output ready);
endinterface

[sv/threshold_rotating_priority_arbiter_unit.sv]
// Top level of the threshold rotating priority arbiter.
//
// Usage: each beat on the request channel carries an 8-bit request_mask, one
// bit per input that holds a packet. The block scans the inputs cyclically from
// its stored start index and returns one beat on the grant channel for every
// request beat: grant_valid, grant_index and start_moved. When the granted input
// is not the start input its service counter counts up; once the count exceeds
// the threshold register, that input becomes the start input and its counter
// clears. An all-zero mask gives a beat with every field zero and no state change.
// The request beat lands in the input register, and the arbitration result is
// then stored in the output register. Throughput is one beat per cycle while the
// receiver takes each beat, since the search and counter update lie between
// those two registers. When the receiver stalls, the result is held and the input
// register keeps taking a beat until it too is full, after which ready drops.
// Reset empties both pipeline registers and clears the start index, all service
// counters and the threshold. The user must write the threshold through the APB
// port only while the block is idle; the block itself does not enforce this.
module threshold_rotating_priority_arbiter_unit #(
    parameter int NUM_INPUTS = trpa_pkg::NumInputsDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    trpa_req_if.sink                      i_req,
    trpa_grant_if.source                  o_grant,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trpa_pkg::ApbAddrW-1:0] paddr,
    input  logic [trpa_pkg::ApbDataW-1:0] pwdata,
    output logic [trpa_pkg::ApbDataW-1:0] prdata,
    output logic                          pready
);
    import trpa_pkg::*;

    localparam int NumLanes = (NUM_INPUTS < MaskW) ? NUM_INPUTS : MaskW;

    logic               r_in_valid;
    logic [MaskW-1:0]   r_in_mask;
    logic               r_out_valid;
    t_grant             r_out;
    t_grant             n_out;
    logic               w_adv;
    logic [ThreshW-1:0] w_threshold;

    trpa_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (w_threshold)
    );

    // The arbitration result is computed from the input register; the state
    // update happens at the same edge that moves the result to the output.
    trpa_arb_core #(
        .NUM_INPUTS (NUM_INPUTS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mask      (r_in_mask),
        .i_fire      (w_adv),
        .i_threshold (w_threshold),
        .o_grant     (n_out)
    );

    // The input stage moves forward whenever the output register is empty or
    // its beat is taken in this cycle.
    assign w_adv       = r_in_valid && (!r_out_valid || o_grant.ready);
    assign i_req.ready = !r_in_valid || w_adv;

    assign o_grant.valid       = r_out_valid;
    assign o_grant.grant_valid = r_out.grant_valid;
    assign o_grant.grant_index = r_out.grant_index;
    assign o_grant.start_moved = r_out.start_moved;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_grant.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_mask <= i_req.request_mask;
        end
        if (w_adv) begin
            r_out <= n_out;
        end
    end

`ifndef NO_ASSERTIONS
    a_moved_needs_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.start_moved |-> r_out.grant_valid)
        else $error("start_moved set on a beat without a grant");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.grant_valid |-> r_out.grant_index == '0)
        else $error("grant_index not zero on a beat without a grant");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.grant_valid |-> int'(r_out.grant_index) < NumLanes)
        else $error("grant_index beyond the requesting inputs");

    a_input_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_out_valid |=> r_out_valid)
        else $error("held request did not reach the output register");
`endif

endmodule

[sv/trpa_apb_regs.sv]
// APB register file holding the service count threshold.
module trpa_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [trpa_pkg::ApbAddrW-1:0] paddr,
    input  logic [trpa_pkg::ApbDataW-1:0] pwdata,
    output logic [trpa_pkg::ApbDataW-1:0] prdata,
    output logic                          pready,
    output logic [trpa_pkg::ThreshW-1:0]  o_threshold
);
    import trpa_pkg::*;

    logic [ThreshW-1:0] r_threshold;
    logic               w_sel_thresh;

    // Bits below the top address bit are the byte offset within a word.
    assign w_sel_thresh = (paddr[ApbAddrW-1] == RegThreshold);
    assign pready       = 1'b1;
    assign o_threshold  = r_threshold;

    always_comb begin
        prdata = '0;
        if (w_sel_thresh) begin
            prdata = ApbDataW'(r_threshold);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (psel && penable && pwrite && pready && w_sel_thresh) begin
            r_threshold <= pwdata[ThreshW-1:0];
        end
    end

endmodule

[sv/trpa_arb_core.sv]
// Rotating priority search with per-input service counters and start index.
module trpa_arb_core #(
    parameter int NUM_INPUTS = trpa_pkg::NumInputsDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [trpa_pkg::MaskW-1:0]   i_mask,
    input  logic                         i_fire,
    input  logic [trpa_pkg::ThreshW-1:0] i_threshold,
    output trpa_pkg::t_grant             o_grant
);
    import trpa_pkg::*;

    // Only the mask bits can request, so inputs past the mask width never move.
    localparam int NumLanes = (NUM_INPUTS < MaskW) ? NUM_INPUTS : MaskW;
    localparam int IdxW     = $clog2(NumLanes);
    localparam int SumW     = IdxW + 1;

    logic [IdxW-1:0]   r_start;
    logic [CountW-1:0] r_count [NumLanes];

    logic [NumLanes-1:0] w_lanes;
    logic                w_found;
    logic [IdxW-1:0]     w_idx;
    logic [CountW-1:0]   w_inc;
    logic                w_other;
    logic                w_move;

    assign w_lanes = i_mask[NumLanes-1:0];

    // Offsets are checked from the farthest back to zero so the nearest ready
    // input at or after the start index wins.
    always_comb begin
        logic [SumW-1:0] v_sum;
        w_found = 1'b0;
        w_idx   = '0;
        for (int k = NumLanes - 1; k >= 0; k--) begin
            v_sum = SumW'(r_start) + SumW'(k);
            if (v_sum >= SumW'(NumLanes)) begin
                v_sum = v_sum - SumW'(NumLanes);
            end
            if (w_lanes[v_sum[IdxW-1:0]]) begin
                w_found = 1'b1;
                w_idx   = v_sum[IdxW-1:0];
            end
        end
    end

    assign w_inc   = r_count[w_idx] + CountW'(1);
    assign w_other = w_found && (w_idx != r_start);
    assign w_move  = w_other && (w_inc > CountW'(i_threshold));

    assign o_grant.grant_valid = w_found;
    assign o_grant.grant_index = GrantIdxW'(w_idx);
    assign o_grant.start_moved = w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            for (int k = 0; k < NumLanes; k++) begin
                r_count[k] <= '0;
            end
        end else if (i_fire && w_other) begin
            if (w_move) begin
                r_start        <= w_idx;
                r_count[w_idx] <= '0;
            end else begin
                r_count[w_idx] <= w_inc;
            end
        end
    end

endmodule
